/* rtl/core/gffs_pkg.sv */
// Shared types, codes and constants of the grid flood fill unit.
package gffs_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;
  localparam int QUEUE_DEPTH = 4096;

  localparam int COORD_W = 6;
  localparam int CODE_W  = 2;
  localparam int COUNT_W = 13;
  localparam int QENT_W  = 2 * COORD_W;
  localparam int CFG_IDX_W = 4;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_FILL  = 2'd2;

  localparam logic [CODE_W-1:0] CODE_UNKNOWN  = 2'd0;
  localparam logic [CODE_W-1:0] CODE_OCCUPIED = 2'd1;
  localparam logic [CODE_W-1:0] CODE_FREE     = 2'd2;
  localparam logic [CODE_W-1:0] CODE_INVALID  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 4'd3;

  localparam logic [COORD_W-1:0] BOUND_LO_RESET = 6'd0;
  localparam logic [COORD_W-1:0] BOUND_HI_RESET = 6'd63;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

  // Neighbour offsets, visited in this order
  localparam logic signed [1:0] STEP_DX [8] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                                 2'sd0, 2'sd1, 2'sd1, 2'sd1};
  localparam logic signed [1:0] STEP_DY [8] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
                                                 2'sd1, -2'sd1, 2'sd0, 2'sd1};

  typedef struct packed {
    logic [1:0]         command;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [CODE_W-1:0]  cell_code_in;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]  cell_code_out;
    logic [COUNT_W-1:0] freed_count;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] lo_x;
    logic [COORD_W-1:0] hi_x;
    logic [COORD_W-1:0] lo_y;
    logic [COORD_W-1:0] hi_y;
  } bounds_t;

  typedef struct packed {
    logic               hit;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } nbr_t;

endpackage

/* rtl/core/grid_flood_fill_free_space_unit.sv */
// Top level: occupancy grid store with write, read and 8-connected flood fill.
//
// Commands are taken when start is high and busy is low; every command gives
// exactly one result, shown on out_data for the single cycle that out_strobe
// is high, and the receiver cannot stall it. A write or an unused command
// answers in the cycle after acceptance and busy stays low; a read answers
// from S_READ, which registers the cell store output as its result. A fill
// first clears the visited map, one cell a cycle, then steps S_EXPAND through
// the eight neighbours of each expanded cell on the shared neighbour address
// unit, with one neighbour read and the previous one evaluated each cycle,
// and passes through S_DRAIN, S_DEQ and S_LOAD to drain the last evaluation
// and fetch the next queue entry. After reset the cell store is cleared to
// unknown in a pass over every cell during which busy is high; configuration
// writes are taken at any time.
module grid_flood_fill_free_space_unit #(
  parameter int GRID_WIDTH  = gffs_pkg::GRID_WIDTH,
  parameter int GRID_HEIGHT = gffs_pkg::GRID_HEIGHT,
  parameter int QUEUE_DEPTH = gffs_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  gffs_pkg::in_item_t             in_data,
  output logic                           out_strobe,
  output gffs_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gffs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gffs_pkg::COORD_W-1:0]   cfg_data
);

  localparam int CELLS   = GRID_WIDTH * GRID_HEIGHT;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int QAW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW     = $clog2(QUEUE_DEPTH + 1);
  localparam int XLAST   = GRID_WIDTH - 1;
  localparam int YLAST   = GRID_HEIGHT - 1;
  localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(CELLS - 1);
  localparam logic [QCW-1:0]     Q_FULL    = QCW'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_READ, S_CLEAR, S_EXPAND, S_DRAIN, S_DEQ, S_LOAD
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CELL_AW-1:0]             sweep_r, sweep_nxt;
  logic [2:0]                     k_r, k_nxt;
  logic [gffs_pkg::COORD_W-1:0]   cx_r, cx_nxt, cy_r, cy_nxt;
  gffs_pkg::bounds_t              cfg_r, cfg_nxt;
  gffs_pkg::bounds_t              bnd_r, bnd_nxt;
  logic [QCW-1:0]                 head_r, head_nxt, tail_r, tail_nxt;
  logic [gffs_pkg::COUNT_W-1:0]   freed_r, freed_nxt;
  logic                           ev_v_r, ev_v_nxt;
  logic [CELL_AW-1:0]             ev_idx_r, ev_idx_nxt;
  logic [gffs_pkg::COORD_W-1:0]   ev_x_r, ev_x_nxt, ev_y_r, ev_y_nxt;
  logic                           rd_ok_r, rd_ok_nxt;
  logic                           out_strobe_r, out_strobe_nxt;
  gffs_pkg::out_item_t            out_data_r, out_data_nxt;

  logic                           accept;
  logic                           on_grid;
  logic [CELL_AW-1:0]             in_idx;
  gffs_pkg::nbr_t                 nbr;
  logic [CELL_AW-1:0]             nbr_idx;

  logic                           cs_we, cs_re;
  logic [CELL_AW-1:0]             cs_waddr, cs_raddr;
  logic [gffs_pkg::CODE_W-1:0]    cs_wdata, cs_rdata;
  logic                           vm_we, vm_re;
  logic [CELL_AW-1:0]             vm_waddr;
  logic                           vm_wdata, vm_rdata;
  logic                           pq_we, pq_re;
  logic [QAW-1:0]                 pq_waddr, pq_raddr;
  logic [gffs_pkg::QENT_W-1:0]    pq_wdata, pq_rdata;

  gffs_nbr_unit #(
    .GRID_WIDTH (GRID_WIDTH),
    .CELL_AW    (CELL_AW)
  ) u_nbr (
    .cx       (cx_r),
    .cy       (cy_r),
    .k        (k_r),
    .bnd      (bnd_r),
    .nbr      (nbr),
    .cell_idx (nbr_idx)
  );

  gffs_ram #(.WIDTH(gffs_pkg::CODE_W), .DEPTH(CELLS), .ADDR_W(CELL_AW)) u_cell_store (
    .clk     (clk),
    .wr_en   (cs_we),
    .wr_addr (cs_waddr),
    .wr_data (cs_wdata),
    .rd_en   (cs_re),
    .rd_addr (cs_raddr),
    .rd_data (cs_rdata)
  );

  gffs_ram #(.WIDTH(1), .DEPTH(CELLS), .ADDR_W(CELL_AW)) u_visited (
    .clk     (clk),
    .wr_en   (vm_we),
    .wr_addr (vm_waddr),
    .wr_data (vm_wdata),
    .rd_en   (vm_re),
    .rd_addr (nbr_idx),
    .rd_data (vm_rdata)
  );

  gffs_ram #(.WIDTH(gffs_pkg::QENT_W), .DEPTH(QUEUE_DEPTH), .ADDR_W(QAW)) u_queue (
    .clk     (clk),
    .wr_en   (pq_we),
    .wr_addr (pq_waddr),
    .wr_data (pq_wdata),
    .rd_en   (pq_re),
    .rd_addr (pq_raddr),
    .rd_data (pq_rdata)
  );

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;
  assign accept     = start && !busy;

  always_comb begin
    on_grid = (int'(in_data.cell_x) < GRID_WIDTH) && (int'(in_data.cell_y) < GRID_HEIGHT);
    in_idx  = CELL_AW'(int'(in_data.cell_y) * GRID_WIDTH + int'(in_data.cell_x));
  end

  always_comb begin
    state_nxt      = state_r;
    sweep_nxt      = sweep_r;
    k_nxt          = k_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    cfg_nxt        = cfg_r;
    bnd_nxt        = bnd_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    freed_nxt      = freed_r;
    ev_v_nxt       = 1'b0;
    ev_idx_nxt     = ev_idx_r;
    ev_x_nxt       = ev_x_r;
    ev_y_nxt       = ev_y_r;
    rd_ok_nxt      = rd_ok_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;

    cs_we    = 1'b0;
    cs_waddr = ev_idx_r;
    cs_wdata = gffs_pkg::CODE_FREE;
    cs_re    = 1'b0;
    cs_raddr = nbr_idx;
    vm_we    = 1'b0;
    vm_waddr = ev_idx_r;
    vm_wdata = 1'b1;
    vm_re    = 1'b0;
    pq_we    = 1'b0;
    pq_waddr = tail_r[QAW-1:0];
    pq_wdata = {ev_y_r, ev_x_r};
    pq_re    = 1'b0;
    pq_raddr = head_r[QAW-1:0];

    if (cfg_valid) begin
      unique case (cfg_index)
        gffs_pkg::REG_MIN_X: cfg_nxt.lo_x = cfg_data;
        gffs_pkg::REG_MAX_X: cfg_nxt.hi_x = cfg_data;
        gffs_pkg::REG_MIN_Y: cfg_nxt.lo_y = cfg_data;
        gffs_pkg::REG_MAX_Y: cfg_nxt.hi_y = cfg_data;
        default: ;
      endcase
    end

    // evaluate the neighbour read in the previous cycle
    if (ev_v_r && !vm_rdata) begin
      vm_we = 1'b1;
      if (cs_rdata != gffs_pkg::CODE_OCCUPIED) begin
        cs_we = 1'b1;
        if (freed_r != gffs_pkg::COUNT_MAX) begin
          freed_nxt = freed_r + 1'b1;
        end
        if (tail_r < Q_FULL) begin
          pq_we    = 1'b1;
          tail_nxt = tail_r + 1'b1;
        end
      end
    end

    unique case (state_r)
      S_INIT: begin
        cs_we    = 1'b1;
        cs_waddr = sweep_r;
        cs_wdata = gffs_pkg::CODE_UNKNOWN;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_CELL) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          out_data_nxt = '0;
          unique case (in_data.command)
            gffs_pkg::CMD_WRITE: begin
              if (on_grid && in_data.cell_code_in != gffs_pkg::CODE_INVALID) begin
                cs_we    = 1'b1;
                cs_waddr = in_idx;
                cs_wdata = in_data.cell_code_in;
              end
              out_strobe_nxt = 1'b1;
            end
            gffs_pkg::CMD_READ: begin
              cs_re     = 1'b1;
              cs_raddr  = in_idx;
              rd_ok_nxt = on_grid;
              state_nxt = S_READ;
            end
            gffs_pkg::CMD_FILL: begin
              cx_nxt   = in_data.cell_x;
              cy_nxt   = in_data.cell_y;
              bnd_nxt  = cfg_r;
              if (int'(cfg_r.hi_x) > XLAST) bnd_nxt.hi_x = gffs_pkg::COORD_W'(XLAST);
              if (int'(cfg_r.hi_y) > YLAST) bnd_nxt.hi_y = gffs_pkg::COORD_W'(YLAST);
              head_nxt  = '0;
              tail_nxt  = '0;
              freed_nxt = '0;
              sweep_nxt = '0;
              state_nxt = S_CLEAR;
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        out_strobe_nxt             = 1'b1;
        out_data_nxt.cell_code_out = rd_ok_r ? cs_rdata : gffs_pkg::CODE_UNKNOWN;
        state_nxt                  = S_IDLE;
      end

      S_CLEAR: begin
        vm_we     = 1'b1;
        vm_waddr  = sweep_r;
        vm_wdata  = 1'b0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_CELL) begin
          sweep_nxt = '0;
          k_nxt     = '0;
          state_nxt = S_EXPAND;
        end
      end

      S_EXPAND: begin
        // issue neighbour k; distinct neighbours never collide with the write
        if (nbr.hit) begin
          vm_re = 1'b1;
          cs_re = 1'b1;
        end
        ev_v_nxt   = nbr.hit;
        ev_idx_nxt = nbr_idx;
        ev_x_nxt   = nbr.x;
        ev_y_nxt   = nbr.y;
        k_nxt      = k_r + 1'b1;
        if (k_r == 3'd7) begin
          state_nxt = S_DRAIN;
        end
      end

      S_DRAIN: begin
        state_nxt = S_DEQ;
      end

      S_DEQ: begin
        if (head_r < tail_r) begin
          pq_re     = 1'b1;
          head_nxt  = head_r + 1'b1;
          state_nxt = S_LOAD;
        end else begin
          out_strobe_nxt           = 1'b1;
          out_data_nxt             = '0;
          out_data_nxt.freed_count = freed_r;
          state_nxt                = S_IDLE;
        end
      end

      S_LOAD: begin
        cx_nxt    = pq_rdata[gffs_pkg::COORD_W-1:0];
        cy_nxt    = pq_rdata[gffs_pkg::QENT_W-1:gffs_pkg::COORD_W];
        k_nxt     = '0;
        state_nxt = S_EXPAND;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      sweep_r      <= '0;
      k_r          <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      freed_r      <= '0;
      ev_v_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      cfg_r.lo_x   <= gffs_pkg::BOUND_LO_RESET;
      cfg_r.hi_x   <= gffs_pkg::BOUND_HI_RESET;
      cfg_r.lo_y   <= gffs_pkg::BOUND_LO_RESET;
      cfg_r.hi_y   <= gffs_pkg::BOUND_HI_RESET;
    end else begin
      state_r      <= state_nxt;
      sweep_r      <= sweep_nxt;
      k_r          <= k_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      freed_r      <= freed_nxt;
      ev_v_r       <= ev_v_nxt;
      out_strobe_r <= out_strobe_nxt;
      cfg_r        <= cfg_nxt;
    end
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    bnd_r      <= bnd_nxt;
    ev_idx_r   <= ev_idx_nxt;
    ev_x_r     <= ev_x_nxt;
    ev_y_r     <= ev_y_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* rtl/core/gffs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gffs_ram #(
  parameter int WIDTH  = 2,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/gffs_nbr_unit.sv */
// Neighbour address unit: offset, bounds check and cell index of one neighbour.
module gffs_nbr_unit #(
  parameter int GRID_WIDTH = gffs_pkg::GRID_WIDTH,
  parameter int CELL_AW    = 12
) (
  input  logic [gffs_pkg::COORD_W-1:0] cx,
  input  logic [gffs_pkg::COORD_W-1:0] cy,
  input  logic [2:0]                   k,
  input  gffs_pkg::bounds_t            bnd,
  output gffs_pkg::nbr_t               nbr,
  output logic [CELL_AW-1:0]           cell_idx
);

  logic signed [7:0] nx_s;
  logic signed [7:0] ny_s;
  logic              in_x;
  logic              in_y;

  always_comb begin
    nx_s = $signed({2'b00, cx}) + 8'(gffs_pkg::STEP_DX[k]);
    ny_s = $signed({2'b00, cy}) + 8'(gffs_pkg::STEP_DY[k]);
    in_x = (nx_s >= $signed({2'b00, bnd.lo_x})) && (nx_s <= $signed({2'b00, bnd.hi_x}));
    in_y = (ny_s >= $signed({2'b00, bnd.lo_y})) && (ny_s <= $signed({2'b00, bnd.hi_y}));
    nbr.hit = in_x && in_y;
    nbr.x   = nx_s[gffs_pkg::COORD_W-1:0];
    nbr.y   = ny_s[gffs_pkg::COORD_W-1:0];
    // upper bounds are clamped to the grid, so a hit always indexes a real cell
    cell_idx = CELL_AW'(int'(nbr.y) * GRID_WIDTH + int'(nbr.x));
  end

endmodule

/* test/grid_flood_fill_free_space_checker.sv */
// Checker for the grid flood fill unit: predicts every result from the requests and compares.
module grid_flood_fill_free_space_checker
  import gffs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  in_item_t             in_data,
  input  logic                 out_strobe,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  output int                   fail_count,
  output int                   outstanding,
  output int                   checked_count
);

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int NB_DX [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
  localparam int NB_DY [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};

  logic [CODE_W-1:0] cell_codes [CELLS];
  bit                visited [CELLS];
  int                frontier [QUEUE_DEPTH];
  bounds_t           bounds;
  out_item_t         expected_q [$];

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Breadth-first walk over 8-connected neighbours; returns the number of cells set free
  function automatic logic [COUNT_W-1:0] flood_free(int sx, int sy);
    int lx, hx, ly, hy, cx, cy, nx, ny, idx, head, tail, freed, i, k;
    bit more;
    lx = bounds.lo_x;
    hx = bounds.hi_x;
    ly = bounds.lo_y;
    hy = bounds.hi_y;
    if (hx > GRID_WIDTH - 1) hx = GRID_WIDTH - 1;
    if (hy > GRID_HEIGHT - 1) hy = GRID_HEIGHT - 1;
    for (i = 0; i < CELLS; i++) visited[i] = 1'b0;
    head = 0;
    tail = 0;
    freed = 0;
    cx = sx;
    cy = sy;
    more = 1'b1;
    // The start cell is expanded first but left unvisited, so it may be reached again
    while (more) begin
      for (k = 0; k < 8; k++) begin
        nx = cx + NB_DX[k];
        ny = cy + NB_DY[k];
        if (nx >= lx && nx <= hx && ny >= ly && ny <= hy) begin
          idx = ny * GRID_WIDTH + nx;
          if (!visited[idx]) begin
            visited[idx] = 1'b1;
            if (cell_codes[idx] != CODE_OCCUPIED) begin
              cell_codes[idx] = CODE_FREE;
              if (freed < int'(COUNT_MAX)) freed++;
              if (tail < QUEUE_DEPTH) begin
                frontier[tail] = idx;
                tail++;
              end
            end
          end
        end
      end
      if (head < tail) begin
        idx = frontier[head];
        head++;
        cx = idx % GRID_WIDTH;
        cy = idx / GRID_WIDTH;
      end else begin
        more = 1'b0;
      end
    end
    return freed[COUNT_W-1:0];
  endfunction

  function automatic out_item_t predict_result(in_item_t req);
    out_item_t res;
    int        idx;
    bit        on_grid;
    res = '0;
    on_grid = req.cell_x < GRID_WIDTH && req.cell_y < GRID_HEIGHT;
    idx = int'(req.cell_y) * GRID_WIDTH + int'(req.cell_x);
    case (req.command)
      CMD_WRITE: begin
        if (on_grid && req.cell_code_in != CODE_INVALID) cell_codes[idx] = req.cell_code_in;
      end
      CMD_READ: begin
        if (on_grid) res.cell_code_out = cell_codes[idx];
      end
      CMD_FILL: begin
        res.freed_count = flood_free(int'(req.cell_x), int'(req.cell_y));
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    int        i;
    if (!rst_n) begin
      for (i = 0; i < CELLS; i++) begin
        cell_codes[i] = CODE_UNKNOWN;
        visited[i] = 1'b0;
      end
      bounds.lo_x = BOUND_LO_RESET;
      bounds.hi_x = BOUND_HI_RESET;
      bounds.lo_y = BOUND_LO_RESET;
      bounds.hi_y = BOUND_HI_RESET;
      expected_q.delete();
    end else begin
      // Compare before taking a new request: no result leaves in its own acceptance cycle
      if (out_strobe) begin
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected result: code %0d count %0d",
                                 out_data.cell_code_out, out_data.freed_count));
        end else begin
          want = expected_q.pop_front();
          checked_count++;
          if (out_data.cell_code_out !== want.cell_code_out ||
              out_data.freed_count !== want.freed_count) begin
            note_failure($sformatf("result %0d: expected code %0d count %0d, got code %0d count %0d",
                                   checked_count, want.cell_code_out, want.freed_count,
                                   out_data.cell_code_out, out_data.freed_count));
          end
        end
      end
      if (start && !busy) expected_q.push_back(predict_result(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_X: bounds.lo_x = cfg_data;
          REG_MAX_X: bounds.hi_x = cfg_data;
          REG_MIN_Y: bounds.lo_y = cfg_data;
          REG_MAX_Y: bounds.hi_y = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = expected_q.size();
  end

endmodule

/* test/grid_flood_fill_free_space_unit_tb.sv */
// Testbench top for the grid flood fill unit: drives requests and bounds, gives the verdict.
module grid_flood_fill_free_space_unit_tb;
  import gffs_pkg::*;

  localparam int CYCLE_LIMIT = 30_000_000;
  localparam logic [1:0]           CMD_SPARE = 2'd3;
  // No register stands behind this index
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd12;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_data;
  logic                 out_strobe;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;

  int fail_count, outstanding, checked_count;
  int cycle_count, sent_count, fill_count, setting_count, idle_pct;
  logic [COORD_W-1:0] win_lo_x, win_hi_x, win_lo_y, win_hi_y;

  grid_flood_fill_free_space_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  grid_flood_fill_free_space_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (in_data),
    .out_strobe    (out_strobe),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycle_count, outstanding);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_request(logic [1:0] cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [CODE_W-1:0] code);
    in_item_t req;
    req.command = cmd;
    req.cell_x = x;
    req.cell_y = y;
    req.cell_code_in = code;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    sent_count++;
    if (cmd == CMD_FILL) fill_count++;
  endtask

  // Hold requests off until every result has come back
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_bounds(logic [COORD_W-1:0] lx, logic [COORD_W-1:0] hx,
                            logic [COORD_W-1:0] ly, logic [COORD_W-1:0] hy);
    wait_idle();
    write_reg(REG_MIN_X, lx);
    write_reg(REG_MAX_X, hx);
    write_reg(REG_MIN_Y, ly);
    write_reg(REG_MAX_Y, hy);
    win_lo_x = lx;
    win_hi_x = hx;
    win_lo_y = ly;
    win_hi_y = hy;
    setting_count++;
  endtask

  // Mostly narrow spans to keep fills short; now and then the whole axis or an inverted pair
  task automatic pick_span(output logic [COORD_W-1:0] lo, output logic [COORD_W-1:0] hi);
    int r, a, b;
    r = $urandom_range(99);
    if (r < 10) begin
      a = 0;
      b = 63;
    end else if (r < 20) begin
      a = $urandom_range(63, 1);
      b = $urandom_range(a - 1, 0);
    end else begin
      a = $urandom_range(63, 0);
      b = a + $urandom_range(7, 0);
      if (b > 63) b = 63;
    end
    lo = a[COORD_W-1:0];
    hi = b[COORD_W-1:0];
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] lo,
                                                     logic [COORD_W-1:0] hi, int near_pct);
    int r;
    r = $urandom_range(99);
    if (r < near_pct) return COORD_W'($urandom_range(hi, lo));
    // Just outside the window
    if (r < near_pct + 10) return $urandom_range(1) ? lo - 6'd1 : hi + 6'd1;
    return COORD_W'($urandom_range(63, 0));
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 40) return CODE_OCCUPIED;
    if (r < 70) return CODE_UNKNOWN;
    if (r < 90) return CODE_FREE;
    return CODE_INVALID;
  endfunction

  task automatic send_random_request();
    int r;
    r = $urandom_range(99);
    if (r < 45)
      send_request(CMD_WRITE, pick_coord(win_lo_x, win_hi_x, 80),
                   pick_coord(win_lo_y, win_hi_y, 80), pick_code());
    else if (r < 75)
      send_request(CMD_READ, pick_coord(win_lo_x, win_hi_x, 70),
                   pick_coord(win_lo_y, win_hi_y, 70), CODE_W'($urandom_range(3)));
    else if (r < 93)
      send_request(CMD_FILL, pick_coord(win_lo_x, win_hi_x, 75),
                   pick_coord(win_lo_y, win_hi_y, 75), CODE_W'($urandom_range(3)));
    else
      send_request(CMD_SPARE, COORD_W'($urandom_range(63)), COORD_W'($urandom_range(63)),
                   CODE_W'($urandom_range(3)));
  endtask

  task automatic run_profile(int pct);
    logic [COORD_W-1:0] lx, hx, ly, hy;
    idle_pct = pct;
    repeat (3) begin
      pick_span(lx, hx);
      pick_span(ly, hy);
      set_bounds(lx, hx, ly, hy);
      repeat (11) send_random_request();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MIN_X;
    cfg_data = '0;
    idle_pct = 29;
    sent_count = 0;
    fill_count = 0;
    setting_count = 0;
    win_lo_x = BOUND_LO_RESET;
    win_hi_x = BOUND_HI_RESET;
    win_lo_y = BOUND_LO_RESET;
    win_hi_y = BOUND_HI_RESET;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Corners, the unused command and the ignored code, under reset bounds
    send_request(CMD_READ, 6'd0, 6'd0, CODE_UNKNOWN);
    send_request(CMD_WRITE, 6'd63, 6'd63, CODE_FREE);
    send_request(CMD_READ, 6'd63, 6'd63, CODE_UNKNOWN);
    send_request(CMD_WRITE, 6'd0, 6'd63, CODE_OCCUPIED);
    send_request(CMD_READ, 6'd0, 6'd63, CODE_INVALID);
    send_request(CMD_WRITE, 6'd5, 6'd5, CODE_INVALID);
    send_request(CMD_READ, 6'd5, 6'd5, CODE_UNKNOWN);
    send_request(CMD_SPARE, 6'd63, 6'd0, CODE_INVALID);
    wait_idle();
    write_reg(REG_SPARE, 6'h3F);

    // Small window: starts outside it, an obstacle, a cell already free
    set_bounds(6'd2, 6'd5, 6'd2, 6'd5);
    send_request(CMD_WRITE, 6'd3, 6'd3, CODE_OCCUPIED);
    send_request(CMD_WRITE, 6'd4, 6'd4, CODE_FREE);
    send_request(CMD_FILL, 6'd0, 6'd0, CODE_UNKNOWN);
    send_request(CMD_FILL, 6'd1, 6'd1, CODE_UNKNOWN);
    send_request(CMD_READ, 6'd2, 6'd2, CODE_UNKNOWN);
    send_request(CMD_FILL, 6'd4, 6'd4, CODE_FREE);

    // Lower bound above upper bound
    set_bounds(6'd40, 6'd10, 6'd0, 6'd63);
    send_request(CMD_FILL, 6'd20, 6'd20, CODE_UNKNOWN);

    // Single-cell window at the far corner
    set_bounds(6'd63, 6'd63, 6'd63, 6'd63);
    send_request(CMD_FILL, 6'd62, 6'd62, CODE_UNKNOWN);
    send_request(CMD_FILL, 6'd63, 6'd63, CODE_UNKNOWN);

    // Whole grid, then one column
    set_bounds(6'd0, 6'd63, 6'd0, 6'd63);
    send_request(CMD_FILL, 6'd0, 6'd0, CODE_UNKNOWN);
    send_request(CMD_READ, 6'd31, 6'd17, CODE_UNKNOWN);
    send_request(CMD_WRITE, 6'd10, 6'd10, CODE_UNKNOWN);
    set_bounds(6'd0, 6'd0, 6'd0, 6'd63);
    send_request(CMD_FILL, 6'd1, 6'd30, CODE_UNKNOWN);
    send_request(CMD_READ, 6'd0, 6'd5, CODE_UNKNOWN);

    run_profile(29);
    run_profile(82);
    run_profile(0);

    wait_idle();
    // Catch any stray result after the last one
    repeat (50) @(negedge clk);

    $display("Covered %0d requests, %0d of them fills, over %0d bound settings.",
             sent_count, fill_count, setting_count);
    $display("Compared %0d results, %0d failures counted.", checked_count, fail_count);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
